// File: rtl/core/oaht_pkg.sv
package oaht_pkg;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_SEARCH = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_FILLED  = 2'd1,
      SLOT_DELETED = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      MODE_LINEAR    = 2'd0,
      MODE_QUADRATIC = 2'd1,
      MODE_DOUBLE    = 2'd2
   } mode_type;

   typedef enum logic [0:0] {
      REG_TABLE_SIZE = 1'd0,
      REG_PROBE_MODE = 1'd1
   } reg_index_type;

   localparam int KEY_W  = 31;
   localparam int DATA_W = 32;
   localparam int SLOT_W = 10;
   localparam int SIZE_W = 11;
   localparam int CSR_W  = 11;

   typedef struct packed {
      logic [1:0]        func;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] data_out;
   } rsp_type;

   typedef enum logic [1:0] {
      FR_IDLE = 2'd0,
      FR_DIV  = 2'd1,
      FR_PUSH = 2'd2
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'd0,
      BK_READ  = 3'd1,
      BK_WAIT  = 3'd2,
      BK_CHECK = 3'd3,
      BK_NEXT  = 3'd4,
      BK_DONE  = 3'd5
   } back_state_type;

endpackage

// File: rtl/core/oaht_ram.sv
module oaht_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: rtl/core/oaht_front.sv
// Hash front: computes h1 = key mod m and h2 = 1 + key mod (m-1) by restoring
// division, one bit per cycle for both, then queues the job.
module oaht_front #(
   parameter int IDX_W = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  oaht_pkg::req_type    req_data,
   input  logic [IDX_W:0]       m_size,
   input  logic                 q_full,
   output logic                 q_push,
   output logic [IDX_W-1:0]     q_h1,
   output logic [IDX_W-1:0]     q_h2,
   output oaht_pkg::req_type    q_req,
   output logic                 busy
);
   import oaht_pkg::*;

   localparam int CNT_W = $clog2(KEY_W + 1);

   front_state_type state_ff, state_in;
   req_type         req_ff;
   logic [IDX_W:0]  r1_ff, r1_in, r2_ff, r2_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [IDX_W+1:0] t1, t2, d1, d2;
   logic [IDX_W:0]  m1;
   logic            kbit;

   assign m1   = m_size - 1'b1;
   assign kbit = req_ff.key[cnt_ff[$clog2(KEY_W)-1:0]];
   assign t1   = {r1_ff, kbit};
   assign t2   = {r2_ff, kbit};
   assign d1   = t1 - {1'b0, m_size};
   assign d2   = t2 - {1'b0, m1};

   always_comb begin
      r1_in = (t1 >= {1'b0, m_size}) ? d1[IDX_W:0] : t1[IDX_W:0];
      r2_in = (t2 >= {1'b0, m1})     ? d2[IDX_W:0] : t2[IDX_W:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: if (start) state_in = FR_DIV;
         FR_DIV:  if (cnt_ff == '0) state_in = FR_PUSH;
         FR_PUSH: if (!q_full) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      busy   = (state_ff != FR_IDLE);
      q_push = (state_ff == FR_PUSH) && !q_full;
      q_h1   = r1_ff[IDX_W-1:0];
      q_h2   = IDX_W'(r2_ff + 1'b1);
      q_req  = req_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == FR_IDLE && start) begin
         req_ff <= req_data;
         r1_ff  <= '0;
         r2_ff  <= '0;
         cnt_ff <= CNT_W'(KEY_W - 1);
      end else if (state_ff == FR_DIV) begin
         r1_ff  <= r1_in;
         r2_ff  <= r2_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end
endmodule

// File: rtl/core/oaht_back.sv
// Probe engine: walks the probe sequence over the slot RAMs, reading, checking
// and stepping to the next slot in the states BK_WAIT, BK_CHECK and BK_NEXT.
module oaht_back #(
   parameter int IDX_W = 10,
   parameter int DEPTH = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  logic [IDX_W-1:0]     q_h1,
   input  logic [IDX_W-1:0]     q_h2,
   input  oaht_pkg::req_type    q_req,
   input  logic [IDX_W:0]       m_size,
   input  logic [1:0]           mode,
   output logic                 q_pop,
   output logic                 rsp_strobe,
   output oaht_pkg::rsp_type    rsp_data,
   output logic                 busy,
   output logic                 clearing
);
   import oaht_pkg::*;

   back_state_type  state_ff, state_in;
   req_type         req_ff;
   logic [IDX_W-1:0] pos_ff, h2_ff, step_ff;
   logic [IDX_W:0]  cnt_ff;
   logic [1:0]      status_ff;
   logic [IDX_W-1:0] slot_ff;
   logic [DATA_W-1:0] data_ff;
   logic            clr_ff;
   logic [IDX_W-1:0] clr_ptr_ff;

   logic [1:0]        st_rd, st_wd;
   logic [KEY_W-1:0]  key_rd;
   logic [DATA_W-1:0] dat_rd;
   logic              st_we, kd_we, hit, stop;
   logic [IDX_W-1:0]  st_wa;
   logic [IDX_W-1:0]  next_pos, next_step;

   oaht_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_state (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(pos_ff), .rd_data(st_rd));
   oaht_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key (
      .clock(clock), .wr_en(kd_we), .wr_addr(pos_ff), .wr_data(req_ff.key),
      .rd_addr(pos_ff), .rd_data(key_rd));
   oaht_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_data (
      .clock(clock), .wr_en(kd_we), .wr_addr(pos_ff), .wr_data(req_ff.payload),
      .rd_addr(pos_ff), .rd_data(dat_rd));

   function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b,
                                                 input logic [IDX_W:0] m);
      logic [IDX_W+1:0] s;
      s = {2'b00, a} + {2'b00, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[IDX_W-1:0];
   endfunction

   // small constant (below 8) reduced modulo m, m at least 2
   function automatic logic [IDX_W-1:0] small_mod(input logic [IDX_W:0] c,
                                                   input logic [IDX_W:0] m);
      logic [IDX_W:0] r;
      r = c;
      for (int n = 0; n < 3; n++) begin
         if (r >= m) r = r - m;
      end
      return r[IDX_W-1:0];
   endfunction

   always_comb begin
      unique case (mode)
         MODE_LINEAR: begin
            next_step = step_ff;
            next_pos  = add_mod(pos_ff, step_ff, m_size);
         end
         MODE_QUADRATIC: begin
            next_pos  = add_mod(pos_ff, step_ff, m_size);
            next_step = add_mod(step_ff, small_mod((IDX_W+1)'(6), m_size), m_size);
         end
         default: begin
            next_step = step_ff;
            next_pos  = add_mod(pos_ff, h2_ff, m_size);
         end
      endcase
   end

   always_comb begin
      hit  = (st_rd == SLOT_FILLED) && (key_rd == req_ff.key);
      stop = (req_ff.func == FUNC_INSERT) ? (st_rd == SLOT_EMPTY)
                                          : ((st_rd == SLOT_EMPTY) || hit);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (!clr_ff && q_valid) state_in = BK_READ;
         BK_READ:  state_in = (req_ff.func == FUNC_NOP) ? BK_DONE : BK_WAIT;
         BK_WAIT:  state_in = BK_CHECK;
         BK_CHECK: state_in = (stop || cnt_ff <= (IDX_W+1)'(1)) ? BK_DONE : BK_NEXT;
         BK_NEXT:  state_in = BK_WAIT;
         BK_DONE:  state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop      = (state_ff == BK_IDLE) && !clr_ff && q_valid;
      busy       = (state_ff != BK_IDLE);
      clearing   = clr_ff;
      rsp_strobe = (state_ff == BK_DONE);
      rsp_data.status   = status_ff;
      rsp_data.slot     = SLOT_W'(slot_ff);
      rsp_data.data_out = data_ff;
      st_we = 1'b0;
      kd_we = 1'b0;
      st_wa = pos_ff;
      st_wd = SLOT_EMPTY;
      if (clr_ff) begin
         st_we = 1'b1;
         st_wa = clr_ptr_ff;
      end else if (state_ff == BK_CHECK && stop) begin
         if (req_ff.func == FUNC_INSERT) begin
            st_we = 1'b1; kd_we = 1'b1; st_wd = SLOT_FILLED;
         end else if (req_ff.func == FUNC_REMOVE && hit) begin
            st_we = 1'b1; st_wd = SLOT_DELETED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         clr_ff     <= 1'b1;
         clr_ptr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clr_ff) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == IDX_W'(DEPTH - 1)) clr_ff <= 1'b0;
         end
      end
      if (q_pop) begin
         req_ff    <= q_req;
         pos_ff    <= q_h1;
         h2_ff     <= q_h2;
         step_ff   <= (mode == MODE_QUADRATIC) ? small_mod((IDX_W+1)'(4), m_size)
                                               : IDX_W'(1);
         cnt_ff    <= m_size;
         status_ff <= (q_req.func == FUNC_INSERT) ? ST_FULL : ST_NOTFOUND;
         slot_ff   <= '0;
         data_ff   <= '0;
      end else if (state_ff == BK_CHECK) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (stop && (req_ff.func == FUNC_INSERT || hit)) begin
            status_ff <= ST_DONE;
            slot_ff   <= pos_ff;
            data_ff   <= (req_ff.func == FUNC_INSERT) ? '0 : dat_rd;
         end
      end else if (state_ff == BK_NEXT) begin
         pos_ff  <= next_pos;
         step_ff <= next_step;
      end
   end
endmodule

// File: rtl/core/open_addressing_hash_table.sv
// Hashing: the 31 key bits are taken one a cycle, then the job is pushed to the
// queue; the back end pops it, reads the slot RAMs, walks up to m probes and
// returns the result. Busy drops once the job is pushed, and the next request
// hashes during the probe walk; the push waits while the queue is full.
// Reset: synchronous; busy stays high while the slot states are swept empty.
// The receiver cannot stall.
module open_addressing_hash_table #(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  oaht_pkg::req_type                   req_data,
   output logic                                rsp_strobe,
   output oaht_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [oaht_pkg::CSR_W-1:0]          csr_wdata
);
   import oaht_pkg::*;

   localparam int IDX_W = $clog2(MAX_SLOTS);

   logic [SIZE_W-1:0] size_ff;
   logic [1:0]        mode_ff;
   logic [IDX_W:0]    m_eff;
   logic              f_busy, b_busy, clearing, q_push, q_pop, qv_ff;
   logic [IDX_W-1:0]  f_h1, f_h2, qh1_ff, qh2_ff;
   req_type           f_req, qreq_ff;

   always_comb begin
      if (size_ff < SIZE_W'(2)) m_eff = (IDX_W+1)'(2);
      else if ({{(IDX_W+1){1'b0}}, size_ff} > (IDX_W+SIZE_W+1)'(MAX_SLOTS))
         m_eff = (IDX_W+1)'(MAX_SLOTS);
      else m_eff = (IDX_W+1)'(size_ff);
   end

   oaht_front #(.IDX_W(IDX_W)) u_front (
      .clock(clock), .reset(reset), .start(start && !busy), .req_data(req_data),
      .m_size(m_eff), .q_full(qv_ff), .q_push(q_push), .q_h1(f_h1), .q_h2(f_h2),
      .q_req(f_req), .busy(f_busy));

   oaht_back #(.IDX_W(IDX_W), .DEPTH(MAX_SLOTS)) u_back (
      .clock(clock), .reset(reset), .q_valid(qv_ff), .q_h1(qh1_ff), .q_h2(qh2_ff),
      .q_req(qreq_ff), .m_size(m_eff), .mode(mode_ff), .q_pop(q_pop),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .busy(b_busy), .clearing(clearing));

   assign busy = f_busy || clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(1024);
         mode_ff <= MODE_DOUBLE;
         qv_ff   <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_TABLE_SIZE) size_ff <= csr_wdata;
         if (csr_we && csr_index == REG_PROBE_MODE) mode_ff <= csr_wdata[1:0];
         if (q_push) qv_ff <= 1'b1;
         else if (q_pop) qv_ff <= 1'b0;
      end
      if (q_push) begin
         qh1_ff  <= f_h1;
         qh2_ff  <= f_h2;
         qreq_ff <= f_req;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(q_push && qv_ff && !q_pop)) else $error("queue overrun");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> qv_ff) else $error("pop of empty queue");
   a_busy_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy) else $error("accept during clear");
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_DONE |-> rsp_data.slot == '0)
      else $error("slot not zero");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> b_busy) else $error("response from idle engine");
endmodule
